// ===== hw/rtl/divider_and_reload_timer_unit_assert.svh =====
// assertion macros shared by the timer checker
`ifndef DIVIDER_AND_RELOAD_TIMER_UNIT_ASSERT_SVH
`define DIVIDER_AND_RELOAD_TIMER_UNIT_ASSERT_SVH

// same-cycle implication, off while reset is asserted
`define DRT_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("drt assertion failed");

// next-cycle implication, off while reset is asserted
`define DRT_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("drt assertion failed");

// next-cycle implication that also covers reset itself
`define DRT_ASSERT_RST(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("drt assertion failed");

`endif

// ===== hw/rtl/drt_pkg.sv =====
// types, codes and tick helper for the divider and reload timer
`default_nettype none

package drt_pkg;

    typedef enum logic [1:0] {
        CMD_ADVANCE = 2'd0,
        CMD_READ    = 2'd1,
        CMD_WRITE   = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        SEL_DIVIDER = 2'd0,
        SEL_COUNTER = 2'd1,
        SEL_MODULO  = 2'd2,
        SEL_CONTROL = 2'd3
    } t_sel;

    typedef enum logic [1:0] {
        PER_256 = 2'd0,
        PER_4   = 2'd1,
        PER_16  = 2'd2,
        PER_64  = 2'd3
    } t_period;

    localparam int unsigned DataW    = 8;
    localparam int unsigned ControlW = 3;
    localparam int unsigned EnableBit = 2;

    // boundary crossings of the selected period between start and start + cycles
    function automatic logic [DataW:0] counter_ticks(input logic [DataW:0]   sum,
                                                      input logic [DataW-1:0] start,
                                                      input t_period          per);
        logic [DataW:0] ticks;
        case (per)
            PER_4:   ticks = (sum >> 2) - {3'b000, start[DataW-1:2]};
            PER_16:  ticks = (sum >> 4) - {5'b00000, start[DataW-1:4]};
            PER_64:  ticks = (sum >> 6) - {7'b0000000, start[DataW-1:6]};
            PER_256: ticks = {{DataW{1'b0}}, sum[DataW]};
            default: ticks = '0;
        endcase
        return ticks;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/divider_and_reload_timer_unit.sv =====
// divider and reload timer: input register, one pass of update logic, result register
//
//  channel  valid        stall         payload
//  in       i_in_valid   o_in_stall    i_command i_reg_select i_write_data i_cycles
//  out      o_out_valid  i_out_stall   o_read_data o_timer_irq
//
// one beat in and one beat out per cycle while out is not stalled; a beat passes both registers in turn
// the timer state is updated in the cycle an item moves into the result register
// synchronous active-low reset clears all timer registers and both valid flags
// a stalled result holds; the input register keeps taking beats while it is empty
// or while its item can move on, so in stall only rises when out is stalled and full
`default_nettype none

module divider_and_reload_timer_unit (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [1:0] i_command,
    input  wire logic [1:0] i_reg_select,
    input  wire logic [7:0] i_write_data,
    input  wire logic [7:0] i_cycles,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic [7:0]      o_read_data,
    output logic            o_timer_irq
);

    localparam int unsigned W = drt_pkg::DataW;

    // input register
    logic                   r_in_valid;
    drt_pkg::t_cmd          r_cmd;
    drt_pkg::t_sel          r_sel;
    logic [W-1:0]           r_wdata;
    logic [W-1:0]           r_cycles;

    // timer state
    logic [W-1:0]                  r_phase, n_phase;
    logic [W-1:0]                  r_divider, n_divider;
    logic [W-1:0]                  r_counter, n_counter;
    logic [W-1:0]                  r_modulo, n_modulo;
    logic [drt_pkg::ControlW-1:0]  r_control, n_control;

    // result register
    logic                   r_out_valid;
    logic [W-1:0]           r_rdata, n_rdata;
    logic                   r_irq, n_irq;

    logic                   out_free;
    logic                   move;
    logic [W:0]             phase_sum;
    logic [W:0]             ticks;
    logic [W:0]             count_sum;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign move       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;

    assign phase_sum = {1'b0, r_phase} + {1'b0, r_cycles};
    assign ticks     = drt_pkg::counter_ticks(phase_sum, r_phase,
                                              drt_pkg::t_period'(r_control[1:0]));
    assign count_sum = {1'b0, r_counter} + ticks;

    always_comb begin
        n_phase   = r_phase;
        n_divider = r_divider;
        n_counter = r_counter;
        n_modulo  = r_modulo;
        n_control = r_control;
        n_rdata   = '0;
        n_irq     = 1'b0;
        case (r_cmd)
            drt_pkg::CMD_ADVANCE: begin
                n_divider = r_divider + {{(W-1){1'b0}}, phase_sum[W]};
                if (r_control[drt_pkg::EnableBit]) begin
                    if (count_sum[W]) begin
                        // reload with modulo plus the excess over 256
                        n_counter = r_modulo + count_sum[W-1:0];
                        n_irq     = 1'b1;
                    end else begin
                        n_counter = count_sum[W-1:0];
                    end
                end
                n_phase = phase_sum[W-1:0];
            end
            drt_pkg::CMD_READ: begin
                case (r_sel)
                    drt_pkg::SEL_DIVIDER: n_rdata = r_divider;
                    drt_pkg::SEL_COUNTER: n_rdata = r_counter;
                    drt_pkg::SEL_MODULO:  n_rdata = r_modulo;
                    drt_pkg::SEL_CONTROL:
                        n_rdata = {{(W-drt_pkg::ControlW){1'b0}}, r_control};
                    default:              n_rdata = '0;
                endcase
            end
            drt_pkg::CMD_WRITE: begin
                case (r_sel)
                    drt_pkg::SEL_DIVIDER: n_divider = '0;
                    drt_pkg::SEL_COUNTER: n_counter = r_wdata;
                    drt_pkg::SEL_MODULO:  n_modulo  = r_wdata;
                    drt_pkg::SEL_CONTROL: n_control = r_wdata[drt_pkg::ControlW-1:0];
                    default:              n_control = r_control;
                endcase
            end
            default: begin
                // unused command leaves everything alone
                n_rdata = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_cmd    <= drt_pkg::t_cmd'(i_command);
            r_sel    <= drt_pkg::t_sel'(i_reg_select);
            r_wdata  <= i_write_data;
            r_cycles <= i_cycles;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= '0;
            r_divider <= '0;
            r_counter <= '0;
            r_modulo  <= '0;
            r_control <= '0;
        end else if (move) begin
            r_phase   <= n_phase;
            r_divider <= n_divider;
            r_counter <= n_counter;
            r_modulo  <= n_modulo;
            r_control <= n_control;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_rdata <= n_rdata;
            r_irq   <= n_irq;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_read_data = r_rdata;
    assign o_timer_irq = r_irq;

endmodule

`default_nettype wire

// ===== hw/rtl/drt_checker.sv =====
// port-level checks for the divider and reload timer, bound to the top level
`default_nettype none

`include "divider_and_reload_timer_unit_assert.svh"

module drt_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_in_stall,
    input wire logic       o_out_valid,
    input wire logic       i_out_stall,
    input wire logic [7:0] o_read_data,
    input wire logic       o_timer_irq
);

    // a stalled result beat stays up and keeps its payload
    `DRT_ASSERT_NXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid)
    `DRT_ASSERT_NXT(a_out_stable, o_out_valid && i_out_stall,
                    $stable(o_read_data) && $stable(o_timer_irq))

    // input only backs up when the result side is full and stalled
    `DRT_ASSERT_IMP(a_in_stall_cause, o_in_stall, o_out_valid && i_out_stall)

    // reset empties both stages
    `DRT_ASSERT_RST(a_reset_empty, !i_rst_n, !o_out_valid && !o_in_stall)

endmodule

bind divider_and_reload_timer_unit drt_checker u_drt_checker (.*);

`default_nettype wire

// ===== test/tb_divider_and_reload_timer_unit.sv =====
// self-checking bench for the divider and reload timer: directed table, then random bus traffic
`default_nettype none

module tb_divider_and_reload_timer_unit;

    localparam logic [1:0]  CmdUnused    = 2'd3;
    localparam int unsigned RandomBeats  = 700;
    localparam int unsigned QuietFrom    = 150;
    localparam int unsigned QuietTo      = 350;
    localparam int unsigned DrainAt      = 420;
    localparam int unsigned CycleLimit   = 100000;
    localparam int unsigned TailCycles   = 8;

    typedef struct packed {
        logic [7:0] rd;
        logic       irq;
    } t_result;

    typedef struct packed {
        logic [1:0] cmd;
        logic [1:0] sel;
        logic [7:0] wdata;
        logic [7:0] cyc;
        logic       typed;
        logic [7:0] rd;
        logic       irq;
    } t_step_row;

    localparam int unsigned NumRows = 27;

    // rows with typed = 1 carry their expected beat, the rest go through the predictor
    localparam t_step_row STEP_ROWS [0:NumRows-1] = '{
        '{drt_pkg::CMD_READ,    drt_pkg::SEL_DIVIDER, 8'h00, 8'h00, 1'b1, 8'h00, 1'b0},
        '{drt_pkg::CMD_READ,    drt_pkg::SEL_COUNTER, 8'h00, 8'h00, 1'b1, 8'h00, 1'b0},
        '{drt_pkg::CMD_READ,    drt_pkg::SEL_MODULO,  8'h00, 8'h00, 1'b1, 8'h00, 1'b0},
        '{drt_pkg::CMD_READ,    drt_pkg::SEL_CONTROL, 8'h00, 8'h00, 1'b1, 8'h00, 1'b0},
        '{drt_pkg::CMD_ADVANCE, drt_pkg::SEL_DIVIDER, 8'h00, 8'hFF, 1'b1, 8'h00, 1'b0},
        '{drt_pkg::CMD_ADVANCE, drt_pkg::SEL_DIVIDER, 8'h00, 8'h01, 1'b1, 8'h00, 1'b0},
        '{drt_pkg::CMD_READ,    drt_pkg::SEL_DIVIDER, 8'h00, 8'h00, 1'b1, 8'h01, 1'b0},
        '{drt_pkg::CMD_WRITE,   drt_pkg::SEL_DIVIDER, 8'hFF, 8'h00, 1'b1, 8'h00, 1'b0},
        '{drt_pkg::CMD_READ,    drt_pkg::SEL_DIVIDER, 8'h00, 8'h00, 1'b1, 8'h00, 1'b0},
        '{drt_pkg::CMD_WRITE,   drt_pkg::SEL_CONTROL, 8'hFF, 8'h00, 1'b1, 8'h00, 1'b0},
        '{drt_pkg::CMD_READ,    drt_pkg::SEL_CONTROL, 8'h00, 8'h00, 1'b1, 8'h07, 1'b0},
        '{drt_pkg::CMD_WRITE,   drt_pkg::SEL_MODULO,  8'hFF, 8'h00, 1'b1, 8'h00, 1'b0},
        '{drt_pkg::CMD_WRITE,   drt_pkg::SEL_COUNTER, 8'hFE, 8'h00, 1'b1, 8'h00, 1'b0},
        '{drt_pkg::CMD_ADVANCE, drt_pkg::SEL_DIVIDER, 8'h00, 8'hFF, 1'b0, 8'h00, 1'b0},
        '{drt_pkg::CMD_READ,    drt_pkg::SEL_COUNTER, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0},
        '{drt_pkg::CMD_WRITE,   drt_pkg::SEL_CONTROL, 8'h05, 8'h00, 1'b1, 8'h00, 1'b0},
        '{drt_pkg::CMD_WRITE,   drt_pkg::SEL_COUNTER, 8'hFF, 8'h00, 1'b1, 8'h00, 1'b0},
        '{drt_pkg::CMD_ADVANCE, drt_pkg::SEL_DIVIDER, 8'h00, 8'h04, 1'b0, 8'h00, 1'b0},
        '{drt_pkg::CMD_WRITE,   drt_pkg::SEL_MODULO,  8'h00, 8'h00, 1'b1, 8'h00, 1'b0},
        '{drt_pkg::CMD_WRITE,   drt_pkg::SEL_CONTROL, 8'h04, 8'h00, 1'b1, 8'h00, 1'b0},
        '{drt_pkg::CMD_ADVANCE, drt_pkg::SEL_DIVIDER, 8'h00, 8'hFF, 1'b0, 8'h00, 1'b0},
        '{CmdUnused,            drt_pkg::SEL_CONTROL, 8'hFF, 8'hFF, 1'b1, 8'h00, 1'b0},
        '{drt_pkg::CMD_WRITE,   drt_pkg::SEL_CONTROL, 8'h02, 8'h00, 1'b1, 8'h00, 1'b0},
        '{drt_pkg::CMD_ADVANCE, drt_pkg::SEL_DIVIDER, 8'h00, 8'hC8, 1'b0, 8'h00, 1'b0},
        '{drt_pkg::CMD_READ,    drt_pkg::SEL_COUNTER, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0},
        '{drt_pkg::CMD_ADVANCE, drt_pkg::SEL_DIVIDER, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0},
        '{drt_pkg::CMD_READ,    drt_pkg::SEL_CONTROL, 8'h00, 8'h00, 1'b1, 8'h02, 1'b0}
    };

    logic       i_clk        = 1'b0;
    logic       i_rst_n      = 1'b0;
    logic       i_in_valid   = 1'b0;
    logic [1:0] i_command    = 2'd0;
    logic [1:0] i_reg_select = 2'd0;
    logic [7:0] i_write_data = 8'd0;
    logic [7:0] i_cycles     = 8'd0;
    logic       i_out_stall  = 1'b0;
    logic       o_in_stall;
    logic       o_out_valid;
    logic [7:0] o_read_data;
    logic       o_timer_irq;

    // predictor copy of the timer state
    logic [7:0] phase_q;
    logic [7:0] div_q;
    logic [7:0] cnt_q;
    logic [7:0] mod_q;
    logic [2:0] ctl_q;

    t_result     pending_timer_results [$];
    t_result     oldest_result;
    logic        quiet       = 1'b0;
    int unsigned err_count   = 0;
    int unsigned cycle_count = 0;
    int unsigned n_advance   = 0;
    int unsigned n_read      = 0;
    int unsigned n_write     = 0;
    int unsigned n_unused    = 0;
    int unsigned irq_seen    = 0;

    divider_and_reload_timer_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_command    (i_command),
        .i_reg_select (i_reg_select),
        .i_write_data (i_write_data),
        .i_cycles     (i_cycles),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_read_data  (o_read_data),
        .o_timer_irq  (o_timer_irq)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    function automatic int unsigned period_log2(input drt_pkg::t_period per);
        case (per)
            drt_pkg::PER_4:   return 2;
            drt_pkg::PER_16:  return 4;
            drt_pkg::PER_64:  return 6;
            default:          return 8;
        endcase
    endfunction

    // multiples of 2^shift passed while the phase moves from start to stop
    function automatic int unsigned crossings(input int unsigned start, input int unsigned stop,
                                              input int unsigned shift);
        return (stop >> shift) - (start >> shift);
    endfunction

    task automatic apply_timer_beat(input logic [1:0] cmd, input logic [1:0] sel,
                                    input logic [7:0] wdata, input logic [7:0] cyc,
                                    output t_result res);
        int unsigned stop;
        int unsigned total;
        res = '0;
        case (cmd)
            drt_pkg::CMD_ADVANCE: begin
                stop  = phase_q + cyc;
                total = div_q + crossings(phase_q, stop, 8);
                div_q = total[7:0];
                if (ctl_q[drt_pkg::EnableBit]) begin
                    total = cnt_q + crossings(phase_q, stop,
                                              period_log2(drt_pkg::t_period'(ctl_q[1:0])));
                    if (total > 255) begin
                        // reload carries the excess past the wrap
                        total   = mod_q + total - 256;
                        res.irq = 1'b1;
                    end
                    cnt_q = total[7:0];
                end
                phase_q = stop[7:0];
            end
            drt_pkg::CMD_READ: begin
                case (sel)
                    drt_pkg::SEL_DIVIDER: res.rd = div_q;
                    drt_pkg::SEL_COUNTER: res.rd = cnt_q;
                    drt_pkg::SEL_MODULO:  res.rd = mod_q;
                    default:              res.rd = {5'b00000, ctl_q};
                endcase
            end
            drt_pkg::CMD_WRITE: begin
                case (sel)
                    drt_pkg::SEL_DIVIDER: div_q = 8'h00;
                    drt_pkg::SEL_COUNTER: cnt_q = wdata;
                    drt_pkg::SEL_MODULO:  mod_q = wdata;
                    default:              ctl_q = wdata[drt_pkg::ControlW-1:0];
                endcase
            end
            default: ;
        endcase
    endtask

    task automatic send_beat(input logic [1:0] cmd, input logic [1:0] sel,
                             input logic [7:0] wdata, input logic [7:0] cyc,
                             input logic typed, input t_result typed_res);
        t_result predicted;
        i_in_valid   <= 1'b1;
        i_command    <= cmd;
        i_reg_select <= sel;
        i_write_data <= wdata;
        i_cycles     <= cyc;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        apply_timer_beat(cmd, sel, wdata, cyc, predicted);
        pending_timer_results.push_back(typed ? typed_res : predicted);
        case (cmd)
            drt_pkg::CMD_ADVANCE: n_advance++;
            drt_pkg::CMD_READ:    n_read++;
            drt_pkg::CMD_WRITE:   n_write++;
            default:              n_unused++;
        endcase
    endtask

    task automatic maybe_idle();
        if (!quiet && $urandom_range(0, 99) < 11) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
    endtask

    // result side: check every accepted beat against the oldest expectation
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (pending_timer_results.size() == 0) begin
                    $display("%0t unexpected beat: read_data %02h timer_irq %0b",
                             $time, o_read_data, o_timer_irq);
                    err_count++;
                end else begin
                    oldest_result = pending_timer_results.pop_front();
                    if (o_read_data !== oldest_result.rd) begin
                        $display("%0t read_data mismatch: expected %02h actual %02h",
                                 $time, oldest_result.rd, o_read_data);
                        err_count++;
                    end
                    if (o_timer_irq !== oldest_result.irq) begin
                        $display("%0t timer_irq mismatch: expected %0b actual %0b",
                                 $time, oldest_result.irq, o_timer_irq);
                        err_count++;
                    end
                end
                if (o_timer_irq === 1'b1) irq_seen++;
            end
            i_out_stall <= !quiet && ($urandom_range(0, 99) < 11);
        end
    end

    initial begin
        while (cycle_count < CycleLimit) @(posedge i_clk);
        $display("timed out after %0d cycles with %0d beats outstanding",
                 cycle_count, pending_timer_results.size());
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        logic [1:0] cmd;
        logic [1:0] sel;
        logic [7:0] wdata;
        logic [7:0] cyc;
        int unsigned pick;
        phase_q = '0;
        div_q   = '0;
        cnt_q   = '0;
        mod_q   = '0;
        ctl_q   = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < NumRows; r++) begin
            send_beat(STEP_ROWS[r].cmd, STEP_ROWS[r].sel, STEP_ROWS[r].wdata,
                      STEP_ROWS[r].cyc, STEP_ROWS[r].typed,
                      '{rd: STEP_ROWS[r].rd, irq: STEP_ROWS[r].irq});
            maybe_idle();
        end

        for (int unsigned k = 0; k < RandomBeats; k++) begin
            quiet = (k >= QuietFrom && k < QuietTo);
            if (k == DrainAt) begin
                // hold the sender until every outstanding beat is back
                i_in_valid <= 1'b0;
                @(posedge i_clk);
                while (pending_timer_results.size() != 0) @(posedge i_clk);
            end
            pick  = $urandom_range(0, 99);
            sel   = 2'($urandom_range(0, 3));
            wdata = 8'($urandom_range(0, 255));
            case ($urandom_range(0, 2))
                0:       cyc = 8'($urandom_range(0, 7));
                1:       cyc = 8'($urandom_range(0, 255));
                default: cyc = 8'($urandom_range(192, 255));
            endcase
            if (pick < 45) begin
                cmd = drt_pkg::CMD_ADVANCE;
            end else if (pick < 70) begin
                cmd = drt_pkg::CMD_READ;
            end else if (pick < 95) begin
                cmd = drt_pkg::CMD_WRITE;
                // keep the counter mostly enabled so overflows keep coming
                if (sel == drt_pkg::SEL_CONTROL && $urandom_range(0, 3) != 0) begin
                    wdata[drt_pkg::EnableBit] = 1'b1;
                end
            end else begin
                cmd = CmdUnused;
            end
            send_beat(cmd, sel, wdata, cyc, 1'b0, '0);
            maybe_idle();
        end
        quiet = 1'b0;

        i_in_valid <= 1'b0;
        while (pending_timer_results.size() != 0) @(posedge i_clk);
        repeat (TailCycles) @(posedge i_clk);

        $display("covered %0d advances, %0d reads, %0d writes, %0d unused commands",
                 n_advance, n_read, n_write, n_unused);
        $display("saw %0d timer interrupts, %0d mismatches", irq_seen, err_count);
        if (err_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

`default_nettype wire
